// ===== design/vdp_pkg.sv =====
// shared constants, codes and types of the vdp cpu port interface
// used by vdp_decode and vdp_cpu_port_interface_core; no dependencies
`default_nettype none
package vdp_pkg;

	localparam int VRAM_ADDR_BITS = 14;
	localparam int VRAM_DEPTH     = 1 << VRAM_ADDR_BITS;
	localparam int CRAM_BYTES     = 64;
	localparam int CRAM_WORDS     = CRAM_BYTES / 2;
	localparam int CRAM_AW        = $clog2(CRAM_WORDS);
	localparam int NUM_REGS       = 16;

	// request operations
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_RASTER = 2'd2;

	// ports
	localparam logic PORT_DATA = 1'b0;
	localparam logic PORT_CTRL = 1'b1;

	// access codes
	localparam logic [1:0] CODE_VRAM_READ = 2'd0;
	localparam logic [1:0] CODE_REG_WRITE = 2'd2;
	localparam logic [1:0] CODE_CRAM      = 2'd3;

	// console kinds
	localparam logic [1:0] KIND_EXT      = 2'd1;
	localparam logic [1:0] KIND_HANDHELD = 2'd2;

	// configuration register indexes
	localparam logic CFG_CONSOLE_KIND = 1'b0;
	localparam logic CFG_PAL_DISPLAY  = 1'b1;

	// display mode codes
	localparam logic [3:0] MODE_TEXT_FIX = 4'h1;
	localparam logic [3:0] MODE_224      = 4'hB;
	localparam logic [3:0] MODE_240      = 4'hE;
	localparam logic [3:0] MODE_PAL_DEP  = 4'hF;

	localparam logic [7:0] LINES_192 = 8'd192;
	localparam logic [7:0] LINES_224 = 8'd224;
	localparam logic [7:0] LINES_240 = 8'd240;

	typedef logic [7:0] reg_file_t [NUM_REGS];

	localparam reg_file_t REG_INIT = '{
		8'h36, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'h00,
		8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef struct packed {
		logic                      irq;
		logic [3:0]                mode;
		logic [7:0]                lines;
		logic [VRAM_ADDR_BITS-1:0] name_base;
		logic [3:0]                backdrop;
	} disp_t;

endpackage
`default_nettype wire

// ===== design/vdp_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none
module vdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== design/vdp_decode.sv =====
// display mode, height, name table, backdrop and interrupt decode from the registers
// depends on vdp_pkg
`default_nettype none
module vdp_decode (
	input  wire logic [1:0]   console_kind,
	input  wire logic         pal_display,
	input  wire logic [7:0]   r0,
	input  wire logic [7:0]   r1,
	input  wire logic [7:0]   r2,
	input  wire logic [7:0]   r7,
	input  wire logic         frame_pend,
	input  wire logic         line_pend,
	output vdp_pkg::disp_t    disp
);
	import vdp_pkg::*;

	logic                      m1, m2, m3, m4;
	logic [3:0]                raw_mode;
	logic [VRAM_ADDR_BITS-1:0] ext_base;

	assign m1       = r1[4];
	assign m3       = r1[3];
	assign m2       = r0[1];
	assign m4       = r0[2];
	assign raw_mode = {m4, m3, m2, m1};
	assign ext_base = {r2[3:2], 4'b0111, 8'h00};

	always_comb begin
		disp.mode      = raw_mode;
		disp.lines     = LINES_192;
		disp.name_base = {r2[3:1], 11'b0};
		disp.backdrop  = r7[3:0];
		disp.irq       = (frame_pend & r1[5]) | (line_pend & r0[4]);
		if (console_kind == KIND_EXT || console_kind == KIND_HANDHELD) begin
			if (raw_mode == MODE_224) begin
				disp.lines     = LINES_224;
				disp.name_base = ext_base;
			end else if (raw_mode == MODE_240) begin
				disp.lines     = LINES_240;
				disp.name_base = ext_base;
			end else if (raw_mode == MODE_PAL_DEP) begin
				if (!pal_display) begin
					disp.lines     = LINES_240;
					disp.name_base = ext_base;
				end
			end else if (m4 && m1 && !m2) begin
				disp.mode = MODE_TEXT_FIX;
			end
		end else if (m4 && m1) begin
			disp.mode = MODE_TEXT_FIX;
		end
	end

endmodule
`default_nettype wire

// ===== design/vdp_cpu_port_interface_core.sv =====
// cpu port interface of a tile video display processor: sequencer, state and memories
// depends on vdp_pkg, vdp_ram and vdp_decode
//
// For each request, on the accept edge the video memory and color memory
// reads are issued, and in the following cycle the read data is merged, the memories
// are written back and the result is loaded into the output register. A new request is
// accepted once that is done, and only while the output register is empty or its result
// is taken in the same cycle, so a waiting result holds off the input.
// After reset a clearing pass zeroes video and color memory, one address a cycle, and
// in_ready stays low until it ends. Configuration writes belong to times
// when no request is in flight and apply to the next request.
`default_nettype none
module vdp_cpu_port_interface_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic                               cfg_index,
	input  wire logic [1:0]                         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [1:0]                         operation,
	input  wire logic                               port,
	input  wire logic [7:0]                         write_data,
	input  wire logic [7:0]                         status_set,
	input  wire logic                               set_vint,
	input  wire logic                               set_hint,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [7:0]                              read_data,
	output logic                                    irq_line,
	output logic [3:0]                              display_mode,
	output logic [7:0]                              screen_lines,
	output logic [vdp_pkg::VRAM_ADDR_BITS-1:0]      name_table_base,
	output logic [3:0]                              backdrop_color,
	output logic                                    palette_update,
	output logic [4:0]                              palette_index,
	output logic [15:0]                             palette_value
);
	import vdp_pkg::*;

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

	state_t                    state_q;
	logic [VRAM_ADDR_BITS-1:0] clr_q;

	logic [1:0]                kind_q;
	logic                      pal_q;

	logic [1:0]                op_q;
	logic                      port_q;
	logic [7:0]                data_q;
	logic [7:0]                sset_q;
	logic                      vint_q;
	logic                      hint_q;

	logic [VRAM_ADDR_BITS-1:0] addr_q, addr_d;
	logic [1:0]                code_q, code_d;
	logic [7:0]                fbl_q, fbl_d;
	logic                      pend_q, pend_d;
	logic [7:0]                rbuf_q, rbuf_d;
	logic [15:0]               cwl_q, cwl_d;
	logic [7:0]                stat_q, stat_d;
	logic                      fint_q, fint_d;
	logic                      lint_q, lint_d;
	reg_file_t                 regs_q, regs_n;
	logic                      reg_we;
	logic [3:0]                reg_idx;

	logic [7:0]                rd;
	logic                      pupd;
	logic [4:0]                pidx;
	logic [15:0]               pval;

	logic                      vram_we, vram_we_x;
	logic [VRAM_ADDR_BITS-1:0] vram_waddr, vram_raddr;
	logic [7:0]                vram_wdata, vram_rdata;

	logic                      cram_we, cram_we_x;
	logic [CRAM_AW-1:0]        cram_waddr, cram_waddr_x, cram_raddr;
	logic [15:0]               cram_wdata, cram_wdata_x, cram_rdata;
	logic [7:0]                cram_old;
	logic [VRAM_ADDR_BITS-1:0] new_addr;

	disp_t                     disp;
	logic                      in_fire;

	assign in_ready = (state_q == S_IDLE) && (!out_valid || out_ready);
	assign in_fire  = in_valid && in_ready;

	// read addresses issued on the accept edge
	assign vram_raddr = (operation == OP_WRITE && port == PORT_CTRL)
		? {write_data[5:0], fbl_q} : addr_q;
	assign cram_raddr = (kind_q == KIND_HANDHELD)
		? addr_q[5:1] : {1'b0, addr_q[4:1]};

	assign vram_we    = (state_q == S_CLEAR) || ((state_q == S_EXEC) && vram_we_x);
	assign vram_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
	assign vram_wdata = (state_q == S_CLEAR) ? 8'h00 : data_q;

	assign cram_we    = (state_q == S_CLEAR) || ((state_q == S_EXEC) && cram_we_x);
	assign cram_waddr = (state_q == S_CLEAR) ? clr_q[CRAM_AW-1:0] : cram_waddr_x;
	assign cram_wdata = (state_q == S_CLEAR) ? 16'h0000 : cram_wdata_x;

	vdp_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vram_waddr),
		.wdata (vram_wdata),
		.raddr (vram_raddr),
		.rdata (vram_rdata)
	);

	vdp_ram #(.WIDTH(16), .DEPTH(CRAM_WORDS)) u_cram (
		.clk   (clk),
		.we    (cram_we),
		.waddr (cram_waddr),
		.wdata (cram_wdata),
		.raddr (cram_raddr),
		.rdata (cram_rdata)
	);

	assign cram_old = addr_q[0] ? cram_rdata[15:8] : cram_rdata[7:0];
	assign new_addr = {data_q[5:0], fbl_q};

	always_comb begin
		addr_d       = addr_q;
		code_d       = code_q;
		fbl_d        = fbl_q;
		pend_d       = pend_q;
		rbuf_d       = rbuf_q;
		cwl_d        = cwl_q;
		stat_d       = stat_q;
		fint_d       = fint_q;
		lint_d       = lint_q;
		reg_we       = 1'b0;
		reg_idx      = data_q[3:0];
		vram_we_x    = 1'b0;
		cram_we_x    = 1'b0;
		cram_waddr_x = cram_raddr;
		cram_wdata_x = cram_rdata;
		rd           = 8'h00;
		pupd         = 1'b0;
		pidx         = 5'd0;
		pval         = 16'h0000;
		unique case (op_q)
			OP_WRITE: begin
				if (port_q == PORT_DATA) begin
					pend_d = 1'b0;
					if (code_q != CODE_CRAM) begin
						vram_we_x = 1'b1;
					end else if (kind_q == KIND_HANDHELD) begin
						if (addr_q[0]) begin
							cwl_d        = {data_q, cwl_q[7:0]};
							cram_we_x    = 1'b1;
							cram_waddr_x = addr_q[5:1];
							cram_wdata_x = {data_q, cwl_q[7:0]};
							pupd         = 1'b1;
							pidx         = addr_q[5:1];
							pval         = {data_q, cwl_q[7:0]};
						end else begin
							cwl_d = {cwl_q[15:8], data_q};
						end
					end else if (cram_old != data_q) begin
						cram_we_x    = 1'b1;
						cram_waddr_x = {1'b0, addr_q[4:1]};
						cram_wdata_x = addr_q[0] ? {data_q, cram_rdata[7:0]}
							: {cram_rdata[15:8], data_q};
						pupd         = 1'b1;
						pidx         = addr_q[4:0];
						pval         = {8'h00, data_q};
					end
					rbuf_d = data_q;
					addr_d = addr_q + 1'b1;
				end else if (!pend_q) begin
					addr_d = {addr_q[13:8], data_q};
					fbl_d  = data_q;
					pend_d = 1'b1;
				end else begin
					pend_d = 1'b0;
					code_d = data_q[7:6];
					addr_d = new_addr;
					if (data_q[7:6] == CODE_VRAM_READ) begin
						rbuf_d = vram_rdata;
						addr_d = new_addr + 1'b1;
					end else if (data_q[7:6] == CODE_REG_WRITE) begin
						reg_we = 1'b1;
					end
				end
			end
			OP_READ: begin
				pend_d = 1'b0;
				if (port_q == PORT_DATA) begin
					rd     = rbuf_q;
					rbuf_d = vram_rdata;
					addr_d = addr_q + 1'b1;
				end else begin
					rd     = stat_q;
					stat_d = 8'h00;
					fint_d = 1'b0;
					lint_d = 1'b0;
				end
			end
			OP_RASTER: begin
				stat_d = stat_q | sset_q;
				fint_d = fint_q | vint_q;
				lint_d = lint_q | hint_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			regs_n[i] = (reg_we && reg_idx == 4'(i)) ? fbl_q : regs_q[i];
		end
	end

	vdp_decode u_decode (
		.console_kind (kind_q),
		.pal_display  (pal_q),
		.r0           (regs_n[0]),
		.r1           (regs_n[1]),
		.r2           (regs_n[2]),
		.r7           (regs_n[7]),
		.frame_pend   (fint_d),
		.line_pend    (lint_d),
		.disp         (disp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_q           <= '0;
			kind_q          <= 2'd0;
			pal_q           <= 1'b0;
			op_q            <= OP_WRITE;
			port_q          <= PORT_DATA;
			data_q          <= 8'h00;
			sset_q          <= 8'h00;
			vint_q          <= 1'b0;
			hint_q          <= 1'b0;
			addr_q          <= '0;
			code_q          <= 2'd0;
			fbl_q           <= 8'h00;
			pend_q          <= 1'b0;
			rbuf_q          <= 8'h00;
			cwl_q           <= 16'h0000;
			stat_q          <= 8'h00;
			fint_q          <= 1'b0;
			lint_q          <= 1'b0;
			regs_q          <= REG_INIT;
			out_valid       <= 1'b0;
			read_data       <= 8'h00;
			irq_line        <= 1'b0;
			display_mode    <= 4'h0;
			screen_lines    <= 8'h00;
			name_table_base <= '0;
			backdrop_color  <= 4'h0;
			palette_update  <= 1'b0;
			palette_index   <= 5'd0;
			palette_value   <= 16'h0000;
		end else begin
			if (cfg_write) begin
				if (cfg_index == CFG_CONSOLE_KIND) begin
					kind_q <= cfg_data;
				end else if (cfg_index == CFG_PAL_DISPLAY) begin
					pal_q <= cfg_data[0];
				end
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						op_q    <= operation;
						port_q  <= port;
						data_q  <= write_data;
						sset_q  <= status_set;
						vint_q  <= set_vint;
						hint_q  <= set_hint;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					addr_q          <= addr_d;
					code_q          <= code_d;
					fbl_q           <= fbl_d;
					pend_q          <= pend_d;
					rbuf_q          <= rbuf_d;
					cwl_q           <= cwl_d;
					stat_q          <= stat_d;
					fint_q          <= fint_d;
					lint_q          <= lint_d;
					regs_q          <= regs_n;
					out_valid       <= 1'b1;
					read_data       <= rd;
					irq_line        <= disp.irq;
					display_mode    <= disp.mode;
					screen_lines    <= disp.lines;
					name_table_base <= disp.name_base;
					backdrop_color  <= disp.backdrop;
					palette_update  <= pupd;
					palette_index   <= pidx;
					palette_value   <= pval;
					state_q         <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
